@@ rtl/core/jsu_pkg.sv @@
// shared types, constants and helpers of the json string unescaper
package jsu_pkg;

  // width of the saturating length counters
  localparam int unsigned LEN_BITS = 16;
  // width of the length fields on the ports
  localparam int unsigned OUT_LEN_BITS = 16;
  // scratch width wide enough for any counter width
  localparam int unsigned EXT_BITS = 33;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // result status codes
  localparam logic [2:0] ST_WORK    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_BADESC  = 3'd3;
  localparam logic [2:0] ST_BADHEX  = 3'd4;
  localparam logic [2:0] ST_EOS     = 3'd5;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic       is_nul;
    logic       is_quote;
    logic       is_bslash;
    logic       is_blank;
    logic       is_hex;
    logic       is_esc;     // simple escape letter
    logic       is_u;
    logic [7:0] esc_val;    // decoded byte of a simple escape
  } cls_item_t;

  typedef logic [LEN_BITS-1:0] len_t;

  // saturating increment
  function automatic len_t len_inc(input len_t c);
    len_t r;
    r = c;
    if (c != {LEN_BITS{1'b1}}) begin
      r = c + len_t'(1);
    end
    return r;
  endfunction

  // clamp a counter to the port width
  function automatic logic [OUT_LEN_BITS-1:0] len_show(input len_t c);
    logic [EXT_BITS-1:0] w;
    logic [EXT_BITS-1:0] lim;
    w   = EXT_BITS'(c);
    lim = EXT_BITS'({OUT_LEN_BITS{1'b1}});
    if (w > lim) begin
      return {OUT_LEN_BITS{1'b1}};
    end
    return w[OUT_LEN_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/jsu_front.sv @@
// front end: accepts text bytes and classifies them
module jsu_front (
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output jsu_pkg::cls_item_t q_item_o
);
  import jsu_pkg::*;

  logic is_dig;
  logic is_lo_hex;
  logic is_up_hex;

  // handshake toward the queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // hex digit ranges
  assign is_dig    = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_lo_hex = (in_byte_i >= 8'h61) && (in_byte_i <= 8'h66);
  assign is_up_hex = (in_byte_i >= 8'h41) && (in_byte_i <= 8'h46);

  // byte classification
  always_comb begin
    q_item_o           = '0;
    q_item_o.raw       = in_byte_i;
    q_item_o.is_nul    = (in_byte_i == CH_NUL);
    q_item_o.is_quote  = (in_byte_i == CH_QUOTE);
    q_item_o.is_bslash = (in_byte_i == CH_BSLASH);
    q_item_o.is_blank  = (in_byte_i == CH_SPACE) || (in_byte_i == CH_TAB) ||
                         (in_byte_i == CH_LF) || (in_byte_i == CH_CR);
    q_item_o.is_hex    = is_dig | is_lo_hex | is_up_hex;
    q_item_o.is_u      = (in_byte_i == CH_U);
    unique case (in_byte_i) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = in_byte_i;
      end
      CH_LC_B: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = CH_BS;
      end
      CH_LC_F: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = CH_FF;
      end
      CH_LC_N: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = CH_LF;
      end
      CH_LC_R: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = CH_CR;
      end
      CH_LC_T: begin
        q_item_o.is_esc  = 1'b1;
        q_item_o.esc_val = CH_TAB;
      end
      default: begin
        q_item_o.is_esc  = 1'b0;
        q_item_o.esc_val = 8'h00;
      end
    endcase
  end

endmodule

@@ rtl/core/jsu_queue.sv @@
// two-entry queue of classified items between front and back
module jsu_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsu_pkg::cls_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               nonempty_o,
  output jsu_pkg::cls_item_t pop_item_o
);
  import jsu_pkg::*;

  cls_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign nonempty_o = (cnt_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/core/jsu_back.sv @@
// back end: string decoding state machine, counters and result register
module jsu_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_nonempty_i,
  input  jsu_pkg::cls_item_t                q_item_i,
  output logic                              q_pop_o,
  output logic                              res_valid_o,
  input  logic                              res_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              out_valid_o,
  output logic [2:0]                        status_o,
  output logic [jsu_pkg::OUT_LEN_BITS-1:0]  content_length_o,
  output logic [jsu_pkg::OUT_LEN_BITS-1:0]  decoded_length_o
);
  import jsu_pkg::*;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] hex_q, hex_d;
  len_t       raw_q, raw_d;
  len_t       dec_q, dec_d;
  logic       rv_q, rv_d;
  logic [7:0] ob_q, ob_d;
  logic       ov_q, ov_d;
  logic [2:0] st_q, st_d;
  logic [OUT_LEN_BITS-1:0] clen_q, clen_d;
  logic [OUT_LEN_BITS-1:0] dlen_q, dlen_d;
  logic       fire;
  logic       bump_raw;
  logic       clr;

  // take an item when the result slot is free or being emptied
  assign fire    = q_nonempty_i & (~rv_q | ~res_stall_i);
  assign q_pop_o = fire;

  // decode one byte
  always_comb begin
    phase_d  = phase_q;
    hex_d    = hex_q;
    st_d     = ST_WORK;
    ob_d     = 8'h00;
    ov_d     = 1'b0;
    bump_raw = 1'b0;
    clr      = 1'b0;
    unique case (phase_q)
      PH_WAIT: begin
        if (q_item_i.is_quote) begin
          clr     = 1'b1;
          phase_d = PH_STR;
        end else if (!q_item_i.is_blank) begin
          st_d = ST_NOQUOTE;
        end
      end
      PH_STR: begin
        if (q_item_i.is_nul) begin
          st_d    = ST_EOS;
          phase_d = PH_WAIT;
        end else if (q_item_i.is_quote) begin
          st_d    = ST_DONE;
          phase_d = PH_WAIT;
        end else if (q_item_i.is_bslash) begin
          bump_raw = 1'b1;
          phase_d  = PH_ESC;
        end else begin
          bump_raw = 1'b1;
          ob_d     = q_item_i.raw;
          ov_d     = 1'b1;
        end
      end
      PH_ESC: begin
        if (q_item_i.is_nul) begin
          st_d    = ST_EOS;
          phase_d = PH_WAIT;
        end else begin
          bump_raw = 1'b1;
          phase_d  = PH_STR;
          if (q_item_i.is_esc) begin
            ob_d = q_item_i.esc_val;
            ov_d = 1'b1;
          end else if (q_item_i.is_u) begin
            phase_d = PH_HEX;
            hex_d   = 2'd3;
          end else begin
            st_d    = ST_BADESC;
            phase_d = PH_WAIT;
          end
        end
      end
      PH_HEX: begin
        if (q_item_i.is_nul) begin
          st_d    = ST_EOS;
          phase_d = PH_WAIT;
        end else if (!q_item_i.is_hex) begin
          bump_raw = 1'b1;
          st_d     = ST_BADHEX;
          phase_d  = PH_WAIT;
        end else begin
          bump_raw = 1'b1;
          ob_d     = q_item_i.raw;
          ov_d     = 1'b1;
          if (hex_q == 2'd0) begin
            phase_d = PH_STR;
          end else begin
            hex_d = hex_q - 2'd1;
          end
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  // counters
  always_comb begin
    raw_d = raw_q;
    dec_d = dec_q;
    if (clr) begin
      raw_d = '0;
      dec_d = '0;
    end else begin
      if (bump_raw) begin
        raw_d = len_inc(raw_q);
      end
      if (ov_d) begin
        dec_d = len_inc(dec_q);
      end
    end
    clen_d = len_show(raw_d);
    dlen_d = len_show(dec_d);
  end

  // result slot occupancy
  always_comb begin
    rv_d = rv_q;
    if (fire) begin
      rv_d = 1'b1;
    end else if (!res_stall_i) begin
      rv_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      hex_q   <= 2'd0;
      raw_q   <= '0;
      dec_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      rv_q <= rv_d;
      if (fire) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
        raw_q   <= raw_d;
        dec_q   <= dec_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ob_q   <= ob_d;
      ov_q   <= ov_d;
      st_q   <= st_d;
      clen_q <= clen_d;
      dlen_q <= dlen_d;
    end
  end

  assign res_valid_o      = rv_q;
  assign out_byte_o       = ob_q;
  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign content_length_o = clen_q;
  assign decoded_length_o = dlen_q;

endmodule

@@ rtl/core/json_string_unescaper.sv @@
// json string unescaper: one text byte in, one result item out per item
// an accepted byte is written into the queue, then decoded into the result register
// throughput: one item per cycle while the result output is not stalled; each byte needs a single decoder state update
// input stalls only when the two-entry queue is full
// reset (async, active low): waiting for an opening quote, length counters zero, queue and
// result slot empty
module json_string_unescaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] content_length_o,
  output logic [15:0] decoded_length_o
);
  import jsu_pkg::*;

  cls_item_t push_item;
  cls_item_t pop_item;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_nonempty;

  // classify incoming bytes
  jsu_front u_front (
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // decouple front and back
  jsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .pop_item_o  (pop_item)
  );

  // decode and emit results
  jsu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_nonempty_i     (q_nonempty),
    .q_item_i         (pop_item),
    .q_pop_o          (q_pop),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .out_byte_o       (out_byte_o),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .content_length_o (content_length_o),
    .decoded_length_o (decoded_length_o)
  );

endmodule
